FILE: hdl/mdb_pkg.sv
package mdb_pkg;

    // default fixed-point fraction width (Q8.24)
    localparam int FRAC_BITS_DEF = 24;

    localparam int VAL_W    = 32;   // coordinate width
    localparam int STEP_W   = 31;
    localparam int MAG_W    = 31;
    localparam int DWELL_W  = 16;
    localparam int PIX_W    = 12;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 64;   // kept product width
    localparam int MUL_W    = 33;   // multiplier operand width (signed)

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // register reset values
    localparam logic signed [VAL_W-1:0] START_X_RST   = -32'sd33554432;
    localparam logic signed [VAL_W-1:0] START_Y_RST   = 32'sd25165824;
    localparam logic [STEP_W-1:0]       STEP_X_RST    = 31'd16384;
    localparam logic [STEP_W-1:0]       STEP_Y_RST    = 31'd16384;
    localparam logic [MAG_W-1:0]        BAILOUT_RST   = 31'd67108864;
    localparam logic [DWELL_W-1:0]      MAX_DWELL_RST = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_STEP_X    = 3'd2,
        REG_STEP_Y    = 3'd3,
        REG_BAILOUT   = 3'd4,
        REG_MAX_DWELL = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [DWELL_W-1:0] dwell;
    } result_t;

    // multiplier operand select
    typedef enum logic [2:0] {
        MUL_CX = 3'd0,
        MUL_CY = 3'd1,
        MUL_XX = 3'd2,
        MUL_YY = 3'd3,
        MUL_XY = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     capture;  // latch pixel
        mul_sel_t mul_sel;
        logic     ld_cx;    // cx from product
        logic     ld_start; // cy, x, y, clear mag/dwell
        logic     ld_xx;
        logic     ld_yy;
        logic     ld_mag;   // update magnitude and dwell with yy
        logic     ld_y;     // new y, latch xx - yy
        logic     ld_x;     // new x
        logic     ld_out;
    } cmd_t;

    typedef struct packed {
        logic cont;      // mag < bailout && dwell < max_dwell
        logic out_free;  // output register can take a result
    } sts_t;

    localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[VAL_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/mdb_ctrl.sv
module mdb_ctrl
    import mdb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_CX   = 12'b0000_0000_0010,
        ST_CY   = 12'b0000_0000_0100,
        ST_SETC = 12'b0000_0000_1000,
        ST_SQX  = 12'b0000_0001_0000,
        ST_SQY  = 12'b0000_0010_0000,
        ST_SQW  = 12'b0000_0100_0000,
        ST_TEST = 12'b0000_1000_0000,
        ST_MXY  = 12'b0001_0000_0000,
        ST_UPD1 = 12'b0010_0000_0000,
        ST_UPD2 = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;   // squares of c, no iteration counted yet

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        first_next   = first_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MUL_XX;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CX;
                end
            end
            ST_CX: begin
                cmd.mul_sel = MUL_CX;
                state_next  = ST_CY;
            end
            ST_CY: begin
                cmd.mul_sel = MUL_CY;
                cmd.ld_cx   = 1'b1;
                state_next  = ST_SETC;
            end
            ST_SETC: begin
                cmd.ld_start = 1'b1;
                first_next   = 1'b1;
                state_next   = ST_SQX;
            end
            ST_SQX: begin
                cmd.mul_sel = MUL_XX;
                state_next  = ST_SQY;
            end
            ST_SQY: begin
                cmd.mul_sel = MUL_YY;
                cmd.ld_xx   = 1'b1;
                state_next  = ST_SQW;
            end
            ST_SQW: begin
                cmd.ld_yy  = 1'b1;
                cmd.ld_mag = !first_reg;
                first_next = 1'b0;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = sts.cont ? ST_MXY : ST_DONE;
            end
            ST_MXY: begin
                cmd.mul_sel = MUL_XY;
                state_next  = ST_UPD1;
            end
            ST_UPD1: begin
                cmd.ld_y   = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                cmd.ld_x   = 1'b1;
                state_next = ST_SQX;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/mdb_dpath.sv
module mdb_dpath
    import mdb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  pixel_t               s_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_result,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    // configuration
    logic signed [VAL_W-1:0] start_x_reg, start_y_reg;
    logic [STEP_W-1:0]       step_x_reg, step_y_reg;
    logic [MAG_W-1:0]        bailout_reg;
    logic [DWELL_W-1:0]      max_dwell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg   <= START_X_RST;
            start_y_reg   <= START_Y_RST;
            step_x_reg    <= STEP_X_RST;
            step_y_reg    <= STEP_Y_RST;
            bailout_reg   <= BAILOUT_RST;
            max_dwell_reg <= MAX_DWELL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_X:   start_x_reg   <= cfg_wr_data[VAL_W-1:0];
                REG_START_Y:   start_y_reg   <= cfg_wr_data[VAL_W-1:0];
                REG_STEP_X:    step_x_reg    <= cfg_wr_data[STEP_W-1:0];
                REG_STEP_Y:    step_y_reg    <= cfg_wr_data[STEP_W-1:0];
                REG_BAILOUT:   bailout_reg   <= cfg_wr_data[MAG_W-1:0];
                REG_MAX_DWELL: max_dwell_reg <= cfg_wr_data[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers
    logic [PIX_W-1:0]         col_reg, row_reg;
    logic signed [VAL_W-1:0]  cx_reg, cy_reg, x_reg, y_reg;
    logic signed [PROD_W-1:0] prod_reg, diff_reg;
    logic [PROD_W-1:0]        xx_reg, yy_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [DWELL_W-1:0]       dwell_reg;

    // shared multiplier, one product per cycle
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;

    always_comb begin
        case (cmd.mul_sel)
            MUL_CX: begin
                mul_a = $signed({{(MUL_W-PIX_W){1'b0}}, col_reg});
                mul_b = $signed({{(MUL_W-STEP_W){1'b0}}, step_x_reg});
            end
            MUL_CY: begin
                mul_a = $signed({{(MUL_W-PIX_W){1'b0}}, row_reg});
                mul_b = $signed({{(MUL_W-STEP_W){1'b0}}, step_y_reg});
            end
            MUL_YY: begin
                mul_a = $signed({y_reg[VAL_W-1], y_reg});
                mul_b = $signed({y_reg[VAL_W-1], y_reg});
            end
            MUL_XY: begin
                mul_a = $signed({x_reg[VAL_W-1], x_reg});
                mul_b = $signed({y_reg[VAL_W-1], y_reg});
            end
            default: begin
                mul_a = $signed({x_reg[VAL_W-1], x_reg});
                mul_b = $signed({x_reg[VAL_W-1], x_reg});
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // sign-extended operands
    logic signed [PROD_W-1:0] start_x_ext, start_y_ext, cx_ext, cy_ext;
    assign start_x_ext = $signed({{(PROD_W-VAL_W){start_x_reg[VAL_W-1]}}, start_x_reg});
    assign start_y_ext = $signed({{(PROD_W-VAL_W){start_y_reg[VAL_W-1]}}, start_y_reg});
    assign cx_ext      = $signed({{(PROD_W-VAL_W){cx_reg[VAL_W-1]}}, cx_reg});
    assign cy_ext      = $signed({{(PROD_W-VAL_W){cy_reg[VAL_W-1]}}, cy_reg});

    logic signed [VAL_W-1:0]  cy_init, y_new, x_new;
    logic [PROD_W-1:0]        msum, mshift;
    logic [MAG_W-1:0]         mag_new;

    assign cy_init = sat32(start_y_ext - prod_reg);
    // 2xy: shift one less than the fraction width
    assign y_new   = sat32((prod_reg >>> (FRAC_BITS - 1)) + cy_ext);
    assign x_new   = sat32((diff_reg >>> FRAC_BITS) + cx_ext);
    assign msum    = xx_reg + $unsigned(prod_reg);
    assign mshift  = msum >> FRAC_BITS;
    assign mag_new = (mshift > PROD_W'(MAG_MAX)) ? MAG_MAX : mshift[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[PROD_W-1:0];
        if (cmd.capture) begin
            col_reg <= s_pixel.column;
            row_reg <= s_pixel.row;
        end
        if (cmd.ld_cx) begin
            cx_reg <= sat32(start_x_ext + prod_reg);
        end
        if (cmd.ld_start) begin
            cy_reg    <= cy_init;
            x_reg     <= cx_reg;
            y_reg     <= cy_init;
            mag_reg   <= '0;
            dwell_reg <= '0;
        end
        if (cmd.ld_xx) begin
            xx_reg <= $unsigned(prod_reg);
        end
        if (cmd.ld_yy) begin
            yy_reg <= $unsigned(prod_reg);
        end
        if (cmd.ld_mag) begin
            mag_reg   <= mag_new;
            dwell_reg <= dwell_reg + DWELL_W'(1);
        end
        if (cmd.ld_y) begin
            diff_reg <= $signed(xx_reg) - $signed(yy_reg);
            y_reg    <= y_new;
        end
        if (cmd.ld_x) begin
            x_reg <= x_new;
        end
    end

    assign sts.cont = (mag_reg < bailout_reg) && (dwell_reg < max_dwell_reg);

    // output register
    logic    m_valid_reg;
    result_t m_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_result_reg.magnitude <= mag_reg;
            m_result_reg.dwell     <= dwell_reg;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_result     = m_result_reg;

endmodule

FILE: hdl/mandelbrot_escape_time.sv
// Mandelbrot escape-time engine.
// Input channel (s_valid/s_ready/s_pixel): one pixel (column, row) per transfer.
// The point c = (start_x + column*step_x, start_y - row*step_y) is iterated as
// z = z*z + c from z = c until |z|^2 reaches bailout or dwell reaches max_dwell.
// Result channel (m_valid/m_ready/m_result): final |z|^2 (saturated) and dwell.
// Config port (cfg_wr_en/cfg_index/cfg_wr_data): single-cycle register write,
// index 0..5 = start_x, start_y, step_x, step_y, bailout, max_dwell; others
// are ignored. Write only while no pixel is in flight.
// Schedule: one shared 33x33 multiplier does every product, so each iteration
// steps through test, x*y, update y, update x, x*x, y*y and magnitude in turn.
// The result becomes valid in the same cycle that s_ready is back high for the
// next pixel. One pixel is in the engine at a time.
// Stall: the result sits in an output register; the engine takes and works on
// the next pixel meanwhile and only waits at the end if the previous result
// has not been taken.
// Reset (aresetn, synchronous, active low): engine idle, output empty,
// config registers back to their defaults (-2.0, 1.5, 2^-10, 2^-10, 4.0, 256).
module mandelbrot_escape_time
    import mdb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // pixel input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pixel_t               s_pixel,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_result
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: owns the iteration loop and the input handshake
    mdb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: config registers, multiplier, z update, output register
    mdb_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: verif/mandelbrot_escape_time_checker.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_checker
    import mdb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  pixel_t               s_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  result_t              m_result,
    output int                   errors,
    output int                   pending,
    output int                   n_checked,
    output int                   n_saturated,
    output int                   deepest_dwell
);

    // wide enough for any exact product or sum of two 32-bit values
    typedef logic signed [65:0] wide_t;

    localparam wide_t COORD_HI = 66'sd2147483647;
    localparam wide_t COORD_LO = -66'sd2147483648;
    localparam wide_t MAG_CEIL = 66'sd2147483647;

    logic signed [VAL_W-1:0] org_re;
    logic signed [VAL_W-1:0] org_im;
    logic [STEP_W-1:0]       pitch_re;
    logic [STEP_W-1:0]       pitch_im;
    logic [MAG_W-1:0]        escape_sq;
    logic [DWELL_W-1:0]      dwell_cap;

    result_t pixel_results[$];

    function automatic wide_t clamp_coord(input wide_t v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic result_t predict_escape(input pixel_t px);
        wide_t cx, cy, zr, zi, nr, ni, sq, mag;
        wide_t col_w, row_w, ore_w, oim_w, pre_w, pim_w, lim_w;
        int unsigned dwell;
        result_t res;
        col_w = wide_t'(px.column);
        row_w = wide_t'(px.row);
        ore_w = wide_t'(org_re);
        oim_w = wide_t'(org_im);
        pre_w = wide_t'(pitch_re);
        pim_w = wide_t'(pitch_im);
        lim_w = wide_t'(escape_sq);
        cx = clamp_coord(ore_w + col_w * pre_w);
        cy = clamp_coord(oim_w - row_w * pim_w);
        zr = cx;
        zi = cy;
        mag = 0;
        dwell = 0;
        while (mag < lim_w && dwell < dwell_cap) begin
            // arithmetic shifts give floor division
            nr = clamp_coord(((zr * zr - zi * zi) >>> FRAC_BITS) + cx);
            ni = clamp_coord(((zr * zi) >>> (FRAC_BITS - 1)) + cy);
            zr = nr;
            zi = ni;
            sq = (zr * zr + zi * zi) >>> FRAC_BITS;
            mag = (sq > MAG_CEIL) ? MAG_CEIL : sq;
            dwell++;
        end
        res.magnitude = mag[MAG_W-1:0];
        res.dwell = dwell[DWELL_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            org_re = START_X_RST;
            org_im = START_Y_RST;
            pitch_re = STEP_X_RST;
            pitch_im = STEP_Y_RST;
            escape_sq = BAILOUT_RST;
            dwell_cap = MAX_DWELL_RST;
            pixel_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_X:   org_re = cfg_wr_data;
                    REG_START_Y:   org_im = cfg_wr_data;
                    REG_STEP_X:    pitch_re = cfg_wr_data[STEP_W-1:0];
                    REG_STEP_Y:    pitch_im = cfg_wr_data[STEP_W-1:0];
                    REG_BAILOUT:   escape_sq = cfg_wr_data[MAG_W-1:0];
                    REG_MAX_DWELL: dwell_cap = cfg_wr_data[DWELL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                n_checked++;
                if (pixel_results.size() == 0) begin
                    $error("result transfer with no pixel outstanding: magnitude %0d dwell %0d",
                           m_result.magnitude, m_result.dwell);
                    errors++;
                end else begin
                    want = pixel_results.pop_front();
                    if (m_result.magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, got %0d",
                               want.magnitude, m_result.magnitude);
                        errors++;
                    end
                    if (m_result.dwell !== want.dwell) begin
                        $error("dwell: expected %0d, got %0d", want.dwell, m_result.dwell);
                        errors++;
                    end
                end
                if (m_result.magnitude == MAG_MAX) n_saturated++;
                if (int'(m_result.dwell) > deepest_dwell) deepest_dwell = int'(m_result.dwell);
            end
            if (s_valid && s_ready) pixel_results.push_back(predict_escape(s_pixel));
        end
        pending = pixel_results.size();
    end

endmodule

FILE: verif/mandelbrot_escape_time_test.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_test;
    import mdb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int ONE           = 1 << FRAC_BITS_DEF;  // 1.0 in Q8.24
    localparam int RANDOM_PIXELS = 1600;
    localparam int CALM_FROM     = 1300;                // no idling past this point
    localparam int TAIL_CYCLES   = 32;
    // slowest transfer-to-transfer gap is one pixel at full dwell plus setup while
    // the receiver stalls; allow three times that
    localparam int STALL_LIMIT   = 3 * (9 + 7 * 65535 + 64);

    // indexes with no register behind them; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    localparam logic [31:0]         FIX_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]         FIX_MIN  = 32'h8000_0000;
    localparam logic [STEP_W-1:0]   STEP_MAX = {STEP_W{1'b1}};
    localparam logic [DWELL_W-1:0]  CAP_MAX  = {DWELL_W{1'b1}};

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    pixel_t               s_pixel;
    logic                 m_valid;
    logic                 m_ready;
    result_t              m_result;

    int errors;
    int pending;
    int n_checked;
    int n_saturated;
    int deepest_dwell;

    int  pixels_sent = 0;
    int  views = 1;          // the reset setting counts as the first
    int  idle_cycles = 0;
    bit  calm = 1'b0;        // set near the end: no gaps, receiver always ready
    bit  gappy = 1'b1;       // per setting: whether the sender idles at all

    mandelbrot_escape_time DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    mandelbrot_escape_time_checker pixel_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .errors        (errors),
        .pending       (pending),
        .n_checked     (n_checked),
        .n_saturated   (n_saturated),
        .deepest_dwell (deepest_dwell)
    );

    initial aclk = 1'b0;
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Watchdog: any transfer or register write restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("mandelbrot_escape_time_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: ready high for a random stretch, then a stall of random length.
    // Runs free of the pixel flow so stalls land on every phase of an iteration.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            if (!calm) begin
                repeat ($urandom_range(1, 40)) @(negedge aclk);
                if (!calm) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
                end
            end
        end
    end

    // One register write per cycle; the enable stays up across a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    // Full register set. Bits above a register's width carry junk, which the
    // block has to drop; optionally follow with writes to unmapped indexes.
    task automatic load_view(input logic [31:0] re0, input logic [31:0] im0,
                             input logic [STEP_W-1:0] dre, input logic [STEP_W-1:0] dim,
                             input logic [MAG_W-1:0] lim, input logic [DWELL_W-1:0] cap,
                             input bit spare);
        write_reg(REG_START_X, re0);
        write_reg(REG_START_Y, im0);
        write_reg(REG_STEP_X, {1'($urandom), dre});
        write_reg(REG_STEP_Y, {1'($urandom), dim});
        write_reg(REG_BAILOUT, {1'($urandom), lim});
        write_reg(REG_MAX_DWELL, {16'($urandom), cap});
        if (spare) begin
            write_reg(IDX_UNMAPPED_LO, $urandom);
            write_reg(IDX_UNMAPPED_HI, $urandom);
        end
        cfg_wr_en <= 1'b0;
        views++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is only dropped when a gap follows, so back-to-back pixels keep it high.
    task automatic send_pixel(input logic [PIX_W-1:0] px_col, input logic [PIX_W-1:0] px_row);
        int gap;
        gap = (!calm && gappy && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= '{column: px_col, row: px_row};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
    endtask

    // Registers change only with nothing in flight: every pixel yields exactly
    // one result, so an empty prediction queue means the engine is idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int                  rnd_start;
        int                  phase_pixels;
        int                  kind;
        logic [31:0]         re0;
        logic [31:0]         im0;
        logic [STEP_W-1:0]   dre;
        logic [STEP_W-1:0]   dim;
        logic [MAG_W-1:0]    lim;
        logic [DWELL_W-1:0]  cap;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting: corners, c = 0 and c = -0.5 (both run to the dwell cap).
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1536);
        send_pixel(12'd1536, 12'd1536);
        send_pixel(12'd4095, 12'd0);

        // Coordinates at the format limits and maximal steps: c saturates,
        // |z|^2 saturates on the first pass and still ends the loop at max bailout.
        drain();
        load_view(FIX_MAX, FIX_MIN, STEP_MAX, STEP_MAX, MAG_MAX, CAP_MAX, 1'b1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);

        // Zero bailout: no iteration at all.
        drain();
        load_view(FIX_MIN, FIX_MAX, '0, '0, '0, 16'd16, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // Zero dwell limit: no iteration at all.
        drain();
        load_view(-ONE, ONE / 2, 31'd1, 31'd1, MAG_MAX, '0, 1'b1);
        send_pixel(12'd1234, 12'd2345);
        send_pixel(12'd4095, 12'd4095);

        // c = 0 never escapes: walks the dwell counter all the way to its top.
        drain();
        load_view('0, '0, '0, '0, MAG_W'(4 * ONE), CAP_MAX, 1'b0);
        send_pixel(12'd4095, 12'd0);

        // Smallest nonzero bailout and dwell limit.
        drain();
        load_view(-3 * ONE / 4, ONE / 4, 31'd64, 31'd64, 31'd1, 16'd1, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // Random settings. Most are a window over the set with a modest dwell
        // limit so that pixels run many iterations; a few are raw register noise,
        // and a few use a deep dwell limit with fewer pixels to keep the run short.
        rnd_start = pixels_sent;
        while (pixels_sent - rnd_start < RANDOM_PIXELS) begin
            drain();
            calm = (pixels_sent - rnd_start >= CALM_FROM);
            gappy = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                re0 = $urandom;
                im0 = $urandom;
                dre = STEP_W'($urandom);
                dim = STEP_W'($urandom);
                lim = MAG_W'($urandom);
                cap = DWELL_W'($urandom_range(0, 40));
                phase_pixels = 60;
            end else begin
                re0 = int'($urandom_range(0, 3 * ONE)) - 5 * ONE / 2;
                im0 = $urandom_range(0, 3 * ONE / 2);
                dre = STEP_W'($urandom_range(0, 1 << $urandom_range(2, 14)));
                dim = STEP_W'($urandom_range(0, 1 << $urandom_range(2, 14)));
                lim = ($urandom_range(0, 3) == 0) ? MAG_W'($urandom) : MAG_W'(4 * ONE);
                if ($urandom_range(0, 7) == 0) begin
                    cap = DWELL_W'($urandom_range(200, 300));
                    phase_pixels = 15;
                end else begin
                    cap = DWELL_W'($urandom_range(1, 48));
                    phase_pixels = 100;
                end
            end
            load_view(re0, im0, dre, dim, lim, cap, 1'($urandom));
            repeat (phase_pixels) begin
                send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
            end
        end

        drain();
        // let any stray result past the last expected one show up
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Covered %0d pixels under %0d register settings, incl. limits and unmapped writes",
                 pixels_sent, views);
        $display("%0d results compared, %0d with saturated magnitude, deepest dwell %0d",
                 n_checked, n_saturated, deepest_dwell);
        if (errors == 0 && pending == 0) begin
            $display("mandelbrot_escape_time_test passed");
        end else begin
            $display("mandelbrot_escape_time_test failed");
        end
        $finish;
    end

endmodule

FILE: mandelbrot_escape_time.f
hdl/mdb_pkg.sv
hdl/mdb_ctrl.sv
hdl/mdb_dpath.sv
hdl/mandelbrot_escape_time.sv
verif/mandelbrot_escape_time_checker.sv
verif/mandelbrot_escape_time_test.sv
